[design/frame_packet_retransmit_cache_core_macros.svh]
// Assertion macros for the retransmit cache.
`ifndef FRAME_PACKET_RETRANSMIT_CACHE_CORE_MACROS_SVH
`define FRAME_PACKET_RETRANSMIT_CACHE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FPRC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPRC_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPRC_ASSERT(label, clk, rst_n, prop, msg)
`define FPRC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[design/fprc_pkg.sv]
// Shared types and codes of the retransmit cache.
package fprc_pkg;
	localparam logic [1:0] OP_STORE = 2'd0;
	localparam logic [1:0] OP_FIND  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] ST_STORED  = 3'd0;
	localparam logic [2:0] ST_BAD_HDR = 3'd1;
	localparam logic [2:0] ST_TOO_LONG = 3'd2;
	localparam logic [2:0] ST_INDEX   = 3'd3;
	localparam logic [2:0] ST_TOO_MANY = 3'd4;
	localparam logic [2:0] ST_HIT     = 3'd5;
	localparam logic [2:0] ST_MISS    = 3'd6;

	typedef enum logic [2:0] {
		S_IDLE, S_LOOKUP, S_LENRD, S_STREAM, S_WAIT, S_OUT
	} fsm_t;
endpackage

[design/fprc_ram.sv]
// Generic single-port-write, one-read RAM with registered read.
module fprc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/frame_packet_retransmit_cache_core.sv]
// Retransmit cache: slot table in flops, lengths and words in RAMs.
// Store: one word per cycle while in_ready is high; the status item is valid the cycle after the last word.
// Find: the first data item follows the lookup, the length read (S_LENRD, S_WAIT) and a word read;
// each further word read issues only once the output register is empty and no read is pending.
// Clear: item the next cycle; miss: via S_LOOKUP, then S_OUT (after S_LENRD, S_WAIT on a zero length).
// Reset clears slot table and control; RAM contents stay undefined until written.
`include "frame_packet_retransmit_cache_core_macros.svh"
module frame_packet_retransmit_cache_core #(
	parameter int SLOTS = 8,
	parameter int MAX_PACKETS = 64,
	parameter int MAX_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] frame_id,
	input  logic [15:0] packet_count,
	input  logic [15:0] packet_index,
	input  logic        header_ok,
	input  logic [15:0] datagram_length,
	input  logic [63:0] data_word,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [63:0] read_word,
	output logic [3:0]  word_bytes,
	output logic [9:0]  found_length,
	output logic        last_result
);
	import fprc_pkg::*;

	localparam int WPP = (MAX_BYTES + 7) / 8;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
	localparam int WW = (WPP > 1) ? $clog2(WPP) : 1;
	localparam int CW = $clog2(MAX_PACKETS + 1);
	localparam int LD = SLOTS * MAX_PACKETS;
	localparam int LA = (LD > 1) ? $clog2(LD) : 1;
	localparam int DD = LD * WPP;
	localparam int DA = (DD > 1) ? $clog2(DD) : 1;
	localparam int PC = $clog2(WPP + 1);

	logic                   used_q  [SLOTS];
	logic [31:0]            frame_q [SLOTS];
	logic [CW-1:0]          cnt_q   [SLOTS];
	logic [MAX_PACKETS-1:0] pv_q    [SLOTS];
	logic [SW-1:0]          next_q;
	logic                   act_q;
	logic [SW-1:0]          tslot_q;
	logic [PW-1:0]          tidx_q;
	logic [15:0]            tlen_q;
	logic [PC-1:0]          pos_q;
	logic [2:0]             verd_q;

	fsm_t                   st_q, st_d;
	logic [SW-1:0]          fslot_q;
	logic [PW-1:0]          fidx_q;
	logic                   fhit_q;
	logic [9:0]             flen_q;
	logic [WW-1:0]          fw_q;
	logic [PC-1:0]          nw_q;
	logic [PC-1:0]          issued_q;
	logic [1:0]             pend_q;

	logic [2:0]  o_st_q;
	logic [63:0] o_w_q;
	logic [3:0]  o_nb_q;
	logic [9:0]  o_len_q;
	logic        o_last_q;
	logic        o_v_q;

	// lookup over the slot table (priority to lowest)
	logic          hit;
	logic [SW-1:0] hslot;
	always_comb begin
		hit = 1'b0;
		hslot = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (used_q[s] && frame_q[s] == frame_id) begin
				hit = 1'b1;
				hslot = SW'(s);
			end
		end
	end

	wire acc = in_valid && in_ready;
	wire out_acc = o_v_q && out_ready;
	wire out_free = !o_v_q || out_ready;

	// store first-word decode
	logic [2:0]    sv_verd;
	logic [SW-1:0] sv_slot;
	logic [CW-1:0] sv_cnt;
	logic          sv_new;
	always_comb begin
		sv_slot = hit ? hslot : next_q;
		sv_new = !hit;
		sv_cnt = CW'(packet_count);
		if (hit && 17'(cnt_q[hslot]) >= 17'(packet_count)) begin
			sv_cnt = cnt_q[hslot];
		end
		if (datagram_length > 16'(MAX_BYTES)) begin
			sv_verd = ST_TOO_LONG;
		end else if (!header_ok) begin
			sv_verd = ST_BAD_HDR;
		end else if (packet_count > 16'(MAX_PACKETS)) begin
			sv_verd = ST_TOO_MANY;
		end else if (17'(packet_index) >= 17'(sv_cnt)) begin
			sv_verd = ST_INDEX;
		end else begin
			sv_verd = ST_STORED;
		end
	end

	wire first = (operation == OP_STORE) && !act_q;
	wire [2:0] cur_verd = first ? sv_verd : verd_q;
	wire [15:0] cur_len = first ? datagram_length : tlen_q;
	wire [PC-1:0] cur_pos = first ? '0 : pos_q;
	wire [SW-1:0] cur_slot = first ? sv_slot : tslot_q;
	wire [PW-1:0] cur_idx = first ? PW'(packet_index) : tidx_q;
	wire wr_word = acc && operation == OP_STORE && cur_verd == ST_STORED
		&& cur_pos < PC'(WPP) && 19'(cur_pos) * 19'd8 < 19'(cur_len);

	// RAMs
	logic [LA-1:0] l_waddr, l_raddr;
	logic [9:0]    l_rdata;
	logic [DA-1:0] d_waddr, d_raddr;
	logic [63:0]   d_rdata;
	wire l_we = acc && first && sv_verd == ST_STORED;
	assign l_waddr = LA'(sv_slot * MAX_PACKETS + int'(PW'(packet_index)));
	assign l_raddr = LA'(fslot_q * MAX_PACKETS + int'(fidx_q));
	assign d_waddr = DA'((int'(cur_slot) * MAX_PACKETS + int'(cur_idx)) * WPP
		+ int'(cur_pos));
	assign d_raddr = DA'((int'(fslot_q) * MAX_PACKETS + int'(fidx_q)) * WPP
		+ int'(issued_q));

	fprc_ram #(.WIDTH(10), .DEPTH(LD)) u_len (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(datagram_length[9:0]),
		.raddr(l_raddr), .rdata(l_rdata)
	);
	fprc_ram #(.WIDTH(64), .DEPTH(DD)) u_word (
		.clk(clk), .we(wr_word), .waddr(d_waddr), .wdata(data_word),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	// stream: issue a read only when the output register and the pending slot allow
	wire issue = st_q == S_STREAM && issued_q < nw_q && pend_q == 2'd0 && !o_v_q;
	logic rd_s1;

	always_comb begin
		st_d = st_q;
		in_ready = 1'b0;
		case (st_q)
			S_IDLE: begin
				in_ready = out_free;
				if (acc && operation == OP_FIND) begin
					st_d = S_LOOKUP;
				end
			end
			S_LOOKUP: st_d = fhit_q ? S_LENRD : S_OUT;
			S_LENRD:  st_d = S_WAIT;
			S_WAIT:   st_d = (l_rdata == 10'd0 || 16'(l_rdata) > 16'(MAX_BYTES))
				? S_OUT : S_STREAM;
			S_STREAM: if (issued_q == nw_q && !rd_s1 && pend_q == 2'd0) begin
				st_d = S_IDLE;
			end
			S_OUT: if (out_free) begin
				st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				used_q[s] <= 1'b0;
				frame_q[s] <= '0;
				cnt_q[s] <= '0;
				pv_q[s] <= '0;
			end
			next_q <= '0;
			act_q <= 1'b0;
			tslot_q <= '0;
			tidx_q <= '0;
			tlen_q <= '0;
			pos_q <= '0;
			verd_q <= '0;
			o_v_q <= 1'b0;
			rd_s1 <= 1'b0;
			issued_q <= '0;
			pend_q <= '0;
		end else begin
			if (out_acc) begin
				o_v_q <= 1'b0;
			end
			rd_s1 <= issue;
			if (issue) begin
				issued_q <= issued_q + PC'(1);
				pend_q <= 2'd1;
			end
			if (acc && operation == OP_STORE) begin
				if (first) begin
					act_q <= 1'b1;
					verd_q <= sv_verd;
					tslot_q <= sv_slot;
					tidx_q <= PW'(packet_index);
					tlen_q <= datagram_length;
					if (sv_verd == ST_STORED || sv_verd == ST_INDEX) begin
						if (sv_new) begin
							used_q[sv_slot] <= 1'b1;
							frame_q[sv_slot] <= frame_id;
							pv_q[sv_slot] <= '0;
							next_q <= (int'(next_q) == SLOTS - 1) ? '0 : next_q + SW'(1);
						end
						cnt_q[sv_slot] <= sv_cnt;
					end
					if (sv_verd == ST_STORED && !sv_new) begin
						pv_q[sv_slot][PW'(packet_index)] <= 1'b0;
					end
				end
				pos_q <= wr_word ? cur_pos + PC'(1) : cur_pos;
				if (last_word) begin
					act_q <= 1'b0;
					if (cur_verd == ST_STORED && cur_len != 16'd0) begin
						pv_q[cur_slot][cur_idx] <= 1'b1;
					end
					o_v_q <= 1'b1;
					o_st_q <= cur_verd;
					o_w_q <= '0;
					o_nb_q <= '0;
					o_len_q <= '0;
					o_last_q <= 1'b1;
				end
			end
			if (acc && operation == OP_CLEAR) begin
				for (int s = 0; s < SLOTS; s++) begin
					used_q[s] <= 1'b0;
					frame_q[s] <= '0;
					cnt_q[s] <= '0;
					pv_q[s] <= '0;
				end
				next_q <= '0;
				act_q <= 1'b0;
				pos_q <= '0;
				verd_q <= '0;
				o_v_q <= 1'b1;
				o_st_q <= ST_MISS;
				o_w_q <= '0;
				o_nb_q <= '0;
				o_len_q <= '0;
				o_last_q <= 1'b1;
			end
			if (acc && operation == OP_FIND) begin
				fslot_q <= hslot;
				fidx_q <= PW'(packet_index);
				fhit_q <= hit && 17'(packet_index) < 17'(cnt_q[hslot])
					&& packet_index < 16'(MAX_PACKETS)
					&& pv_q[hslot][PW'(packet_index)];
				issued_q <= '0;
				pend_q <= '0;
			end
			if (st_q == S_WAIT) begin
				flen_q <= l_rdata;
				nw_q <= PC'((int'(l_rdata) + 7) / 8);
				fw_q <= '0;
			end
			if (st_q == S_OUT && out_free) begin
				o_v_q <= 1'b1;
				o_st_q <= ST_MISS;
				o_w_q <= '0;
				o_nb_q <= '0;
				o_len_q <= '0;
				o_last_q <= 1'b1;
			end
			// word data arrives the cycle after issue
			if (rd_s1) begin
				logic [12:0] rem;
				logic [3:0]  nb;
				rem = 13'(flen_q) - 13'({fw_q, 3'b000});
				nb = (rem < 13'd8) ? rem[3:0] : 4'd8;
				o_v_q <= 1'b1;
				o_st_q <= ST_HIT;
				for (int b = 0; b < 8; b++) begin
					o_w_q[b*8 +: 8] <= (4'(b) < nb) ? d_rdata[b*8 +: 8] : 8'd0;
				end
				o_nb_q <= nb;
				o_len_q <= flen_q;
				o_last_q <= (PC'(fw_q) + PC'(1)) == nw_q;
				fw_q <= fw_q + WW'(1);
				pend_q <= 2'd0;
			end
		end
	end

	assign out_valid = o_v_q;
	assign status = o_st_q;
	assign read_word = o_w_q;
	assign word_bytes = o_nb_q;
	assign found_length = o_len_q;
	assign last_result = o_last_q;

	`FPRC_ASSERT(a_ready_idle, clk, arst_n, in_ready |-> st_q == S_IDLE, "ready outside idle")
	`FPRC_ASSERT(a_issue_free, clk, arst_n, issue |=> !o_v_q, "output busy at read return")
	`FPRC_ASSERT(a_nb_range, clk, arst_n, out_valid |-> word_bytes <= 4'd8, "byte count range")
endmodule
